>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use checks one property on clk and
// is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QVR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked against a past value or a later cycle.
`define QVR_ASSERT_SEQ(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

`endif

>>> rtl/qvr_pkg.sv
`default_nettype none
package qvr_pkg;
  localparam int QW  = 16;       // quaternion component width
  localparam int VW  = 32;       // vector component width
  localparam int PW  = 2 * QW;   // product of two quaternion parts
  localparam int CW  = PW + 2;   // rotation matrix coefficient, scaled by |q|^2
  localparam int NW  = PW + 1;   // squared norm, unsigned
  localparam int MW  = CW + VW;  // coefficient times vector component
  localparam int SW  = MW + 2;   // sum of three products
  localparam int QB  = VW + 1;   // quotient magnitude bits
  localparam int LAT = QB + 6;   // cycles from accepted beat to result strobe

  typedef logic [SW-1:0] num_t;
  typedef logic [NW-1:0] den_t;
  typedef logic [QB-1:0] quo_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } tag_t;
endpackage
`default_nettype wire

>>> rtl/qvr_div3.sv
`default_nettype none
module qvr_div3 (
  input  logic                clk,
  input  logic                rst,
  input  qvr_pkg::tag_t       in_tag,
  input  qvr_pkg::den_t       in_den,
  input  qvr_pkg::num_t [2:0] in_mag,
  input  logic          [2:0] in_neg,
  output qvr_pkg::tag_t       out_tag,
  output qvr_pkg::quo_t [2:0] out_quo,
  output logic          [2:0] out_neg
);
  import qvr_pkg::*;

  // Restoring divider, one quotient bit per stage for three lanes. The work
  // word shifts numerator bits out at the top and quotient bits in at the bottom.
  tag_t tag  [QB+1];
  den_t den  [QB+1];
  den_t rem  [QB+1][3];
  quo_t work [QB+1][3];
  logic neg  [QB+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else begin
      tag[0] <= in_tag;
    end
    den[0] <= in_den;
  end

  for (genvar l = 0; l < 3; l++) begin : g_load
    // The quotient is known to fit in QB bits, so the top part is below the divisor.
    always_ff @(posedge clk) begin
      rem[0][l]  <= in_mag[l][QB +: NW];
      work[0][l] <= in_mag[l][QB-1:0];
      neg[0][l]  <= in_neg[l];
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[s+1] <= '0;
      end else begin
        tag[s+1] <= tag[s];
      end
      den[s+1] <= den[s];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NW:0] trial;
      logic [NW:0] diff;
      logic        ge;

      always_comb begin
        trial = {rem[s][l], work[s][l][QB-1]};
        diff  = trial - {1'b0, den[s]};
        ge    = trial >= {1'b0, den[s]};
      end

      always_ff @(posedge clk) begin
        rem[s+1][l]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
        work[s+1][l] <= {work[s][l][QB-2:0], ge};
        neg[s+1][l]  <= neg[s][l];
      end
    end
  end

  assign out_tag = tag[QB];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_quo[l] = work[QB][l];
    assign out_neg[l] = neg[QB][l];
  end
endmodule
`default_nettype wire

>>> rtl/quaternion_vector_rotate.sv
// Throughput: one beat per cycle; busy is always low, so start may be held high.
// The 33-stage restoring divider, one quotient bit per stage, sets the latency.
// Reset (rst, synchronous, active high) clears every valid bit; beats in flight are dropped.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module quaternion_vector_rotate (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [qvr_pkg::QW-1:0] quat_w,
  input  logic signed [qvr_pkg::QW-1:0] quat_x,
  input  logic signed [qvr_pkg::QW-1:0] quat_y,
  input  logic signed [qvr_pkg::QW-1:0] quat_z,
  input  logic signed [qvr_pkg::VW-1:0] vec_x,
  input  logic signed [qvr_pkg::VW-1:0] vec_y,
  input  logic signed [qvr_pkg::VW-1:0] vec_z,
  output logic                     done,
  output logic signed [qvr_pkg::VW-1:0] rot_x,
  output logic signed [qvr_pkg::VW-1:0] rot_y,
  output logic signed [qvr_pkg::VW-1:0] rot_z,
  output logic                     zero_quat,
  output logic                     clipped
);
  import qvr_pkg::*;

  // Nothing ever holds the pipeline, so a beat is taken in every cycle.
  assign busy = 1'b0;

  // Stage 1: the ten products of quaternion parts, and the vector.
  logic                 v1, z1;
  logic signed [PW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [VW-1:0] vec1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    z1 <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
    ww <= PW'(quat_w) * PW'(quat_w);
    xx <= PW'(quat_x) * PW'(quat_x);
    yy <= PW'(quat_y) * PW'(quat_y);
    zz <= PW'(quat_z) * PW'(quat_z);
    xy <= PW'(quat_x) * PW'(quat_y);
    wz <= PW'(quat_w) * PW'(quat_z);
    xz <= PW'(quat_x) * PW'(quat_z);
    wy <= PW'(quat_w) * PW'(quat_y);
    yz <= PW'(quat_y) * PW'(quat_z);
    wx <= PW'(quat_w) * PW'(quat_x);
    vec1[0] <= vec_x;
    vec1[1] <= vec_y;
    vec1[2] <= vec_z;
  end

  // Stage 2: the rotation matrix scaled by the squared norm, and the norm itself.
  // coef[i][j] is the weight of vector component j in result component i.
  logic                 v2, z2;
  logic signed [CW-1:0] coef [3][3];
  den_t                 nrm2;
  logic signed [VW-1:0] vec2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    z2 <= z1;
    coef[0][0] <= CW'(ww) + CW'(xx) - CW'(yy) - CW'(zz);
    coef[0][1] <= (CW'(xy) - CW'(wz)) <<< 1;
    coef[0][2] <= (CW'(xz) + CW'(wy)) <<< 1;
    coef[1][0] <= (CW'(xy) + CW'(wz)) <<< 1;
    coef[1][1] <= CW'(ww) - CW'(xx) + CW'(yy) - CW'(zz);
    coef[1][2] <= (CW'(yz) - CW'(wx)) <<< 1;
    coef[2][0] <= (CW'(xz) - CW'(wy)) <<< 1;
    coef[2][1] <= (CW'(yz) + CW'(wx)) <<< 1;
    coef[2][2] <= CW'(ww) - CW'(xx) - CW'(yy) + CW'(zz);
    nrm2 <= NW'(ww) + NW'(xx) + NW'(yy) + NW'(zz);
    vec2 <= vec1;
  end

  // Stage 3: nine exact coefficient-by-component products.
  logic                 v3, z3;
  logic signed [MW-1:0] prod [3][3];
  den_t                 nrm3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    z3   <= z2;
    nrm3 <= nrm2;
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        prod[i][j] <= MW'(coef[i][j]) * MW'(vec2[j]);
      end
    end
  end

  // Stage 4: the numerator of each component, exact.
  logic                 v4, z4;
  logic signed [SW-1:0] numer [3];
  den_t                 nrm4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    z4   <= z3;
    nrm4 <= nrm3;
  end

  for (genvar i = 0; i < 3; i++) begin : g_sum
    always_ff @(posedge clk) begin
      numer[i] <= SW'(prod[i][0]) + SW'(prod[i][1]) + SW'(prod[i][2]);
    end
  end

  // The divider works on magnitudes; the sign comes back at the end, which
  // gives truncation toward zero.
  tag_t           div_tag_in, div_tag_out;
  num_t     [2:0] div_mag;
  logic     [2:0] div_neg_in, div_neg_out;
  quo_t     [2:0] div_quo;

  always_comb begin
    div_tag_in.valid = v4;
    div_tag_in.zero  = z4;
    for (int i = 0; i < 3; i++) begin
      div_neg_in[i] = numer[i][SW-1];
      div_mag[i]    = numer[i][SW-1] ? num_t'(-numer[i]) : num_t'(numer[i]);
    end
  end

  qvr_div3 u_div (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (div_tag_in),
    .in_den  (nrm4),
    .in_mag  (div_mag),
    .in_neg  (div_neg_in),
    .out_tag (div_tag_out),
    .out_quo (div_quo),
    .out_neg (div_neg_out)
  );

  // Output stage: restore the sign and saturate to the vector range. A zero
  // quaternion forces a zero vector and leaves the clip flag low.
  localparam quo_t POS_LIM = quo_t'((64'd1 << (VW - 1)) - 64'd1);
  localparam quo_t NEG_LIM = quo_t'(64'd1 << (VW - 1));

  logic [VW-1:0] res_next [3];
  logic    [2:0] clip_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_neg_out[i]) begin
        clip_next[i] = div_quo[i] > NEG_LIM;
        res_next[i]  = clip_next[i] ? NEG_LIM[VW-1:0] : VW'(-div_quo[i][VW-1:0]);
      end else begin
        clip_next[i] = div_quo[i] > POS_LIM;
        res_next[i]  = clip_next[i] ? POS_LIM[VW-1:0] : div_quo[i][VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_tag_out.valid;
    end
    zero_quat <= div_tag_out.zero;
    if (div_tag_out.zero) begin
      rot_x   <= '0;
      rot_y   <= '0;
      rot_z   <= '0;
      clipped <= 1'b0;
    end else begin
      rot_x   <= res_next[0];
      rot_y   <= res_next[1];
      rot_z   <= res_next[2];
      clipped <= |clip_next;
    end
  end

  // Every accepted beat produces its strobe after the fixed latency, and no
  // strobe appears without a beat behind it.
  `QVR_ASSERT_SEQ(a_latency, start && !busy, ##LAT done, "result strobe missing")
  `QVR_ASSERT_SEQ(a_origin, done, $past(start && !rst, LAT), "result strobe without beat")
  `QVR_ASSERT_NOW(a_zero_out, done && zero_quat,
                  rot_x == '0 && rot_y == '0 && rot_z == '0 && !clipped,
                  "zero quaternion gave a nonzero result")
endmodule
`default_nettype wire
